[design/ehd_pkg.sv]
// ----------------------------------------------------------------------------
// ehd_pkg: shared types and constants for the escape hex decoder
// Request and result payloads, escape state codes and the hex digit decode.
// ----------------------------------------------------------------------------
package ehd_pkg;

	localparam logic [7:0] ESC_CHAR = 8'h3D;

	// escape tracking: idle, '=' seen, '=' plus first character seen
	localparam logic [1:0] PEND_IDLE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} nib_t;

	// result of one decode step
	typedef struct packed {
		logic [1:0] pend;
		logic [7:0] first;
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} step_t;

	function automatic nib_t hex_nibble(input logic [7:0] c);
		nib_t r;
		r.ok  = 1'b0;
		r.val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.ok  = 1'b1;
			r.val = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r.ok  = 1'b1;
			r.val = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

[design/ehd_step.sv]
// ----------------------------------------------------------------------------
// ehd_step: one decode step
// From the escape state and one request, gives the next state and 0-2 results.
// ----------------------------------------------------------------------------
module ehd_step
	import ehd_pkg::*;
(
	input  logic [1:0] pend,
	input  logic [7:0] first,
	input  req_t       req,
	output step_t      step
);

	nib_t hi;
	nib_t lo;

	assign hi = hex_nibble(first);
	assign lo = hex_nibble(req.in_byte);

	always_comb begin
		step.pend  = PEND_IDLE;
		step.first = first;
		step.cnt   = 2'd0;
		step.res0  = '0;
		step.res1  = '0;
		case (pend)
			PEND_ONE: begin
				if (req.in_last) begin
					// escape cut short: '=' then the character, raw
					step.cnt  = 2'd2;
					step.res0 = '{out_byte: ESC_CHAR, run_end: 1'b0};
					step.res1 = '{out_byte: req.in_byte, run_end: 1'b1};
				end else begin
					step.first = req.in_byte;
					step.pend  = PEND_TWO;
				end
			end
			PEND_TWO: begin
				if (hi.ok && lo.ok) begin
					step.cnt  = 2'd1;
					step.res0 = '{out_byte: {hi.val, lo.val}, run_end: 1'b1};
				end else begin
					// not hex: both characters raw, '=' dropped
					step.cnt  = 2'd2;
					step.res0 = '{out_byte: first, run_end: 1'b0};
					step.res1 = '{out_byte: req.in_byte, run_end: 1'b1};
				end
			end
			default: begin
				// idle; the unused code behaves the same
				if (req.in_byte == ESC_CHAR) begin
					if (req.in_last) begin
						step.cnt  = 2'd1;
						step.res0 = '{out_byte: ESC_CHAR, run_end: 1'b1};
					end else begin
						step.pend = PEND_ONE;
					end
				end else begin
					step.cnt  = 2'd1;
					step.res0 = '{out_byte: req.in_byte, run_end: 1'b1};
				end
			end
		endcase
	end

endmodule

[design/escape_hex_decoder.sv]
// ----------------------------------------------------------------------------
// escape_hex_decoder: streaming '=XX' hex escape decoder
// One character per request; gives zero, one or two decoded bytes per request.
// ----------------------------------------------------------------------------
// Path: a request accepted from src passes the input register, then the result
//   queue, before its first result appears on dst.
// Throughput: one request per cycle while each gives at most one result and dst
//   does not stall; the single output port gives one result at a time.
// Reset (arst_n low, asynchronous): input stage and result queue empty, no
//   escape pending, stored first character cleared.
module escape_hex_decoder
	import ehd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  req_t src_req,
	output logic dst_valid,
	input  logic dst_stall,
	output res_t dst_res
);

	// input stage
	logic valid_s1;
	req_t req_s1;

	// escape state
	logic [1:0] pend_q;
	logic [7:0] first_q;

	// two-entry result queue, entry 0 is the head
	logic [1:0] cnt_q;
	res_t       q0_q;
	res_t       q1_q;

	step_t      step;
	logic       pop;
	logic       adv;
	logic       accept;
	logic [1:0] room;
	logic [1:0] cnt_mid;
	logic [1:0] cnt_n;
	res_t       q0_n;
	res_t       q1_n;

	ehd_step u_step (
		.pend  (pend_q),
		.first (first_q),
		.req   (req_s1),
		.step  (step)
	);

	assign dst_valid = (cnt_q != 2'd0);
	assign dst_res   = q0_q;
	assign pop       = dst_valid && !dst_stall;

	// slots free once this cycle's pop has gone
	assign room = 2'd2 - cnt_q + {1'b0, pop};
	// the staged request moves on only if all its results fit
	assign adv       = valid_s1 && (step.cnt <= room);
	assign src_stall = valid_s1 && !adv;
	assign accept    = src_valid && !src_stall;

	always_comb begin
		cnt_mid = cnt_q - {1'b0, pop};
		q0_n    = q0_q;
		q1_n    = q1_q;
		if (pop) begin
			q0_n = q1_q;
		end
		cnt_n = cnt_mid;
		if (adv) begin
			cnt_n = cnt_mid + step.cnt;
			if (cnt_mid == 2'd0) begin
				q0_n = step.res0;
				q1_n = step.res1;
			end else if (cnt_mid == 2'd1) begin
				// one entry left: room guaranteed at most one new result
				q1_n = step.res0;
			end
			// full queue: only a request without results moves on
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= PEND_IDLE;
			first_q  <= 8'd0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				pend_q  <= step.pend;
				first_q <= step.first;
			end
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= src_req;
		end
		q0_q <= q0_n;
		q1_q <= q1_n;
	end

	// queue never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	// end of message always closes any escape
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.in_last |=> pend_q == PEND_IDLE)
		else $error("escape left open after end of message");

	// end of message always yields at least one result
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.in_last |-> step.cnt != 2'd0)
		else $error("end of message produced no result");

	// a request without results only ever opens or extends an escape
	a_silent_pending: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step.cnt == 2'd0 |=> pend_q != PEND_IDLE)
		else $error("silent request left no escape pending");

	// a staged request that cannot move on stalls the source
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("staged request lost while stalled");

endmodule
